// File: hdl/pre_pkg.sv
// ----------------------------------------------------------------------------
// pre_pkg
// shared types and constants of the pinhole reprojection error unit
// ----------------------------------------------------------------------------
`default_nettype none

package pre_pkg;

  // default image size in pixels
  localparam int unsigned DefImageWidth  = 1024;
  localparam int unsigned DefImageHeight = 1024;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_CAM_X  = 3'd0,
    CFG_CAM_Y  = 3'd1,
    CFG_CAM_Z  = 3'd2,
    CFG_QUAT_W = 3'd3,
    CFG_QUAT_I = 3'd4,
    CFG_QUAT_J = 3'd5,
    CFG_QUAT_K = 3'd6,
    CFG_FOCAL  = 3'd7
  } cfg_idx_e;

  // configuration reset values
  localparam logic signed [31:0] CamRst   = 32'sd0;
  localparam logic signed [31:0] QuatWRst = 32'sh4000_0000;
  localparam logic signed [31:0] QuatVRst = 32'sd0;
  localparam logic        [31:0] FocalRst = 32'd657289839;

  // one input item
  typedef struct packed {
    logic signed [31:0] obj_x;
    logic signed [31:0] obj_y;
    logic signed [31:0] obj_z;
    logic signed [31:0] meas_x;
    logic signed [31:0] meas_y;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic signed [31:0] proj_x;
    logic signed [31:0] proj_y;
    logic        [31:0] error_dist;
    logic               depth_fault;
  } out_item_t;

endpackage

`default_nettype wire

// File: hdl/pre_in_if.sv
// ----------------------------------------------------------------------------
// pre_in_if
// valid/ready channel carrying object points and measured pixels
// ----------------------------------------------------------------------------
`default_nettype none

interface pre_in_if;
  logic             valid;
  logic             ready;
  pre_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/pre_out_if.sv
// ----------------------------------------------------------------------------
// pre_out_if
// valid/ready channel carrying projected pixels and distances
// ----------------------------------------------------------------------------
`default_nettype none

interface pre_out_if;
  logic              valid;
  logic              ready;
  pre_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/pinhole_reprojection_error_unit.sv
// ----------------------------------------------------------------------------
// pinhole_reprojection_error_unit
// camera-relative rotation, pinhole projection and pixel distance, pipelined
// ----------------------------------------------------------------------------
// throughput: one item per cycle unless the output stalls, set by the fully pipelined divider and root
// a stall at the output freezes the whole pipeline, nothing dropped or repeated
// reset clears all valid bits and loads the default camera, quaternion, focal
// rotation matrix follows a configuration write through the product and matrix registers
`default_nettype none

module pinhole_reprojection_error_unit #(
  parameter int unsigned IMAGE_WIDTH  = pre_pkg::DefImageWidth,
  parameter int unsigned IMAGE_HEIGHT = pre_pkg::DefImageHeight
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  pre_in_if.sink           in_i,
  pre_out_if.source        out_o
);

  // stage counts
  localparam int DivBits = 4;               // quotient bits per divider stage
  localparam int DivStg  = 40 / DivBits;    // 40 quotient bits below the cap
  localparam int SqBits  = 4;               // root bits per root stage
  localparam int SqStg   = 32 / SqBits;     // 32 root bits
  localparam int NumStg  = 6 + DivStg + 3 + 2 + SqStg + 1;

  // image centre in Q16.16
  localparam logic signed [42:0] CenterX = 43'((IMAGE_WIDTH - 1) * 32768);
  localparam logic signed [42:0] CenterY = 43'((IMAGE_HEIGHT - 1) * 32768);

  localparam logic signed [37:0] Q30One  = 38'sh0_4000_0000;
  localparam logic signed [37:0] Sat32Hi = 38'sh0_7FFF_FFFF;
  localparam logic signed [37:0] Sat32Lo = -38'sh0_8000_0000;
  localparam logic signed [42:0] Proj32Hi = 43'sh0_7FFF_FFFF;
  localparam logic signed [42:0] Proj32Lo = -43'sh0_8000_0000;
  localparam logic [63:0]        SqLimit  = 64'hFFFF_FFFF_0000_0000;

  // --------------------------------------------------------------------------
  // arithmetic helpers
  // --------------------------------------------------------------------------

  // round a Q30-scaled product, ties up
  function automatic logic signed [34:0] round30(input logic signed [64:0] p);
    logic signed [65:0] t;
    t = $signed({p[64], p}) + 66'sd536870912;
    return $signed(t[64:30]);
  endfunction

  // matrix entry 2*(a +/- b) minus one on the diagonal, saturated
  function automatic logic signed [31:0] mat_entry(input logic signed [34:0] a,
                                                   input logic signed [34:0] b,
                                                   input logic negb,
                                                   input logic diag);
    logic signed [37:0] ea;
    logic signed [37:0] eb;
    logic signed [37:0] s;
    ea = $signed({{3{a[34]}}, a});
    eb = $signed({{3{b[34]}}, b});
    s  = negb ? (ea - eb) : (ea + eb);
    s  = (s <<< 1) - (diag ? Q30One : 38'sd0);
    if (s > Sat32Hi) begin
      return Sat32Hi[31:0];
    end else if (s < Sat32Lo) begin
      return Sat32Lo[31:0];
    end
    return s[31:0];
  endfunction

  // 32 x 32 signed product
  function automatic logic signed [64:0] mul32s(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return $signed({p[63], p});
  endfunction

  // magnitude of a rotated coordinate
  function automatic logic [34:0] mag37(input logic signed [36:0] v);
    logic [36:0] m;
    m = v[36] ? 37'(-v) : v;
    return m[34:0];
  endfunction

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic signed [31:0] cam_x_q, cam_y_q, cam_z_q;
  logic signed [31:0] quat_w_q, quat_i_q, quat_j_q, quat_k_q;
  logic        [31:0] focal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q  <= pre_pkg::CamRst;
      cam_y_q  <= pre_pkg::CamRst;
      cam_z_q  <= pre_pkg::CamRst;
      quat_w_q <= pre_pkg::QuatWRst;
      quat_i_q <= pre_pkg::QuatVRst;
      quat_j_q <= pre_pkg::QuatVRst;
      quat_k_q <= pre_pkg::QuatVRst;
      focal_q  <= pre_pkg::FocalRst;
    end else if (cfg_we_i) begin
      unique case (pre_pkg::cfg_idx_e'(cfg_idx_i))
        pre_pkg::CFG_CAM_X:  cam_x_q  <= cfg_data_i;
        pre_pkg::CFG_CAM_Y:  cam_y_q  <= cfg_data_i;
        pre_pkg::CFG_CAM_Z:  cam_z_q  <= cfg_data_i;
        pre_pkg::CFG_QUAT_W: quat_w_q <= cfg_data_i;
        pre_pkg::CFG_QUAT_I: quat_i_q <= cfg_data_i;
        pre_pkg::CFG_QUAT_J: quat_j_q <= cfg_data_i;
        pre_pkg::CFG_QUAT_K: quat_k_q <= cfg_data_i;
        pre_pkg::CFG_FOCAL:  focal_q  <= cfg_data_i;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // rotation matrix from the quaternion, two register steps, free running
  // --------------------------------------------------------------------------
  logic signed [34:0] qww_q, qwi_q, qwj_q, qwk_q, qii_q;
  logic signed [34:0] qij_q, qik_q, qjj_q, qjk_q, qkk_q;
  logic signed [31:0] mat_q [9];

  always_ff @(posedge clk_i) begin
    qww_q <= round30(mul32s(quat_w_q, quat_w_q));
    qwi_q <= round30(mul32s(quat_w_q, quat_i_q));
    qwj_q <= round30(mul32s(quat_w_q, quat_j_q));
    qwk_q <= round30(mul32s(quat_w_q, quat_k_q));
    qii_q <= round30(mul32s(quat_i_q, quat_i_q));
    qij_q <= round30(mul32s(quat_i_q, quat_j_q));
    qik_q <= round30(mul32s(quat_i_q, quat_k_q));
    qjj_q <= round30(mul32s(quat_j_q, quat_j_q));
    qjk_q <= round30(mul32s(quat_j_q, quat_k_q));
    qkk_q <= round30(mul32s(quat_k_q, quat_k_q));
  end

  always_ff @(posedge clk_i) begin
    mat_q[0] <= mat_entry(qww_q, qii_q, 1'b0, 1'b1);
    mat_q[1] <= mat_entry(qij_q, qwk_q, 1'b0, 1'b0);
    mat_q[2] <= mat_entry(qik_q, qwj_q, 1'b1, 1'b0);
    mat_q[3] <= mat_entry(qij_q, qwk_q, 1'b1, 1'b0);
    mat_q[4] <= mat_entry(qww_q, qjj_q, 1'b0, 1'b1);
    mat_q[5] <= mat_entry(qjk_q, qwi_q, 1'b0, 1'b0);
    mat_q[6] <= mat_entry(qik_q, qwj_q, 1'b0, 1'b0);
    mat_q[7] <= mat_entry(qjk_q, qwi_q, 1'b1, 1'b0);
    mat_q[8] <= mat_entry(qww_q, qkk_q, 1'b0, 1'b1);
  end

  // --------------------------------------------------------------------------
  // pipeline control: one enable, valid bits shift with the data
  // --------------------------------------------------------------------------
  logic [NumStg-1:0] vld_q;
  logic              en;

  assign en           = !vld_q[NumStg-1] || out_o.ready;
  assign in_i.ready   = en;
  assign out_o.valid  = vld_q[NumStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NumStg-2:0], in_i.valid};
    end
  end

  // --------------------------------------------------------------------------
  // s1: point minus camera, exact at 33 bits
  // s2: alignment stage, gives the matrix time to follow a config write
  // s3: nine products of matrix entry and vector component
  // s4: rounded dot products
  // s5: signs, depth check, focal times magnitude
  // --------------------------------------------------------------------------
  logic signed [32:0] v1_q [3];
  logic signed [32:0] v2_q [3];
  logic signed [31:0] mx1_q, my1_q, mx2_q, my2_q, mx3_q, my3_q, mx4_q, my4_q;
  logic signed [31:0] mx5_q, my5_q;
  logic signed [64:0] pr3_q [9];
  logic signed [36:0] r4_q [3];
  logic               fault5_q;
  logic               neg5_q [2];
  logic [34:0]        ad5_q;
  logic [66:0]        n5_q [2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      v1_q[0] <= $signed({in_i.data.obj_x[31], in_i.data.obj_x})
               - $signed({cam_x_q[31], cam_x_q});
      v1_q[1] <= $signed({in_i.data.obj_y[31], in_i.data.obj_y})
               - $signed({cam_y_q[31], cam_y_q});
      v1_q[2] <= $signed({in_i.data.obj_z[31], in_i.data.obj_z})
               - $signed({cam_z_q[31], cam_z_q});
      mx1_q   <= in_i.data.meas_x;
      my1_q   <= in_i.data.meas_y;

      v2_q    <= v1_q;
      mx2_q   <= mx1_q;
      my2_q   <= my1_q;

      for (int e = 0; e < 9; e++) begin
        pr3_q[e] <= v2_q[e % 3] * mat_q[e];
      end
      mx3_q   <= mx2_q;
      my3_q   <= my2_q;

      for (int r = 0; r < 3; r++) begin
        r4_q[r] <= 37'(round30(pr3_q[3*r])) + 37'(round30(pr3_q[3*r+1]))
                 + 37'(round30(pr3_q[3*r+2]));
      end
      mx4_q   <= mx3_q;
      my4_q   <= my3_q;

      // zero depth gets a harmless divisor, its result is forced later
      fault5_q  <= (r4_q[2] == '0);
      ad5_q     <= (r4_q[2] == '0) ? 35'd1 : mag37(r4_q[2]);
      neg5_q[0] <= r4_q[0][36] ^ r4_q[2][36];
      neg5_q[1] <= r4_q[1][36] ^ r4_q[2][36];
      n5_q[0]   <= 67'(focal_q) * 67'(mag37(r4_q[0]));
      n5_q[1]   <= 67'(focal_q) * 67'(mag37(r4_q[1]));
      mx5_q     <= mx4_q;
      my5_q     <= my4_q;
    end
  end

  // --------------------------------------------------------------------------
  // divider: cap check, then restoring division of the low 40 bits,
  // four quotient bits per stage; index 0 is the cap check stage
  // --------------------------------------------------------------------------
  logic [34:0]        dv_rem_q   [DivStg+1][2];
  logic [39:0]        dv_quo_q   [DivStg+1][2];
  logic [39:0]        dv_lo_q    [DivStg+1][2];
  logic               dv_sat_q   [DivStg+1][2];
  logic               dv_neg_q   [DivStg+1][2];
  logic [34:0]        dv_ad_q    [DivStg+1];
  logic               dv_fault_q [DivStg+1];
  logic signed [31:0] dv_mx_q    [DivStg+1];
  logic signed [31:0] dv_my_q    [DivStg+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 2; c++) begin
        // quotient reaches the cap exactly when the top bits reach the divisor
        dv_sat_q[0][c] <= {8'd0, n5_q[c][66:40]} >= ad5_q;
        dv_rem_q[0][c] <= {8'd0, n5_q[c][66:40]};
        dv_lo_q[0][c]  <= n5_q[c][39:0];
        dv_quo_q[0][c] <= '0;
        dv_neg_q[0][c] <= neg5_q[c];
      end
      dv_ad_q[0]    <= ad5_q;
      dv_fault_q[0] <= fault5_q;
      dv_mx_q[0]    <= mx5_q;
      dv_my_q[0]    <= my5_q;
    end
  end

  for (genvar g = 0; g < DivStg; g++) begin : g_div
    logic [34:0] rem_d [2];
    logic [39:0] quo_d [2];

    always_comb begin
      logic [35:0] t;
      t = '0;
      for (int c = 0; c < 2; c++) begin
        rem_d[c] = dv_rem_q[g][c];
        quo_d[c] = dv_quo_q[g][c];
        for (int b = 0; b < DivBits; b++) begin
          t = {rem_d[c], dv_lo_q[g][c][39-b]};
          if (t >= {1'b0, dv_ad_q[g]}) begin
            rem_d[c] = 35'(t - {1'b0, dv_ad_q[g]});
            quo_d[c] = {quo_d[c][38:0], 1'b1};
          end else begin
            rem_d[c] = t[34:0];
            quo_d[c] = {quo_d[c][38:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int c = 0; c < 2; c++) begin
          dv_rem_q[g+1][c] <= rem_d[c];
          dv_quo_q[g+1][c] <= quo_d[c];
          dv_lo_q[g+1][c]  <= dv_lo_q[g][c] << DivBits;
          dv_sat_q[g+1][c] <= dv_sat_q[g][c];
          dv_neg_q[g+1][c] <= dv_neg_q[g][c];
        end
        dv_ad_q[g+1]    <= dv_ad_q[g];
        dv_fault_q[g+1] <= dv_fault_q[g];
        dv_mx_q[g+1]    <= dv_mx_q[g];
        dv_my_q[g+1]    <= dv_my_q[g];
      end
    end
  end

  // --------------------------------------------------------------------------
  // r1: round half away from zero, apply cap and sign
  // r2: add the image centre, saturate, zero on a depth fault
  // r3: pixel differences as magnitudes
  // q1: squares, q2: sum and range check
  // --------------------------------------------------------------------------
  logic signed [41:0] val1_q [2];
  logic               fault1_q, fault2_q, fault3_q, fault4_q, fault6_q;
  logic signed [31:0] mxr_q, myr_q, mxr2_q, myr2_q;
  logic signed [31:0] px2_q [2];
  logic signed [31:0] px3_q [2];
  logic signed [31:0] px4_q [2];
  logic signed [31:0] px6_q [2];
  logic [31:0]        u3_q [2];
  logic [63:0]        sq4_q [2];
  logic [64:0]        sum_w;

  assign sum_w = {1'b0, sq4_q[0]} + {1'b0, sq4_q[1]};

  always_ff @(posedge clk_i) begin
    logic [40:0]        mag;
    logic signed [42:0] pc;
    logic signed [32:0] d;
    if (en) begin
      for (int c = 0; c < 2; c++) begin
        if (dv_sat_q[DivStg][c]) begin
          mag = 41'h100_0000_0000;
        end else begin
          mag = {1'b0, dv_quo_q[DivStg][c]}
              + 41'({dv_rem_q[DivStg][c], 1'b0} >= {1'b0, dv_ad_q[DivStg]});
        end
        val1_q[c] <= dv_neg_q[DivStg][c] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      end
      fault1_q <= dv_fault_q[DivStg];
      mxr_q    <= dv_mx_q[DivStg];
      myr_q    <= dv_my_q[DivStg];

      for (int c = 0; c < 2; c++) begin
        pc = $signed({val1_q[c][41], val1_q[c]}) + ((c == 0) ? CenterX : CenterY);
        if (fault1_q) begin
          px2_q[c] <= '0;
        end else if (pc > Proj32Hi) begin
          px2_q[c] <= Proj32Hi[31:0];
        end else if (pc < Proj32Lo) begin
          px2_q[c] <= Proj32Lo[31:0];
        end else begin
          px2_q[c] <= pc[31:0];
        end
      end
      fault2_q <= fault1_q;
      mxr2_q   <= mxr_q;
      myr2_q   <= myr_q;

      for (int c = 0; c < 2; c++) begin
        d = $signed({((c == 0) ? mxr2_q[31] : myr2_q[31]), ((c == 0) ? mxr2_q : myr2_q)})
          - $signed({px2_q[c][31], px2_q[c]});
        u3_q[c] <= d[32] ? 32'(-d) : d[31:0];
      end
      px3_q    <= px2_q;
      fault3_q <= fault2_q;

      for (int c = 0; c < 2; c++) begin
        sq4_q[c] <= 64'(u3_q[c]) * 64'(u3_q[c]);
      end
      px4_q    <= px3_q;
      fault4_q <= fault3_q;
    end
  end

  // --------------------------------------------------------------------------
  // square root, two radicand bits per step, four steps per stage;
  // index 0 holds the range-checked sum
  // --------------------------------------------------------------------------
  logic [33:0]        sr_rem_q   [SqStg+1];
  logic [31:0]        sr_root_q  [SqStg+1];
  logic [63:0]        sr_rad_q   [SqStg+1];
  logic               sr_ovf_q   [SqStg+1];
  logic               sr_fault_q [SqStg+1];
  logic signed [31:0] sr_px_q    [SqStg+1][2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sr_rem_q[0]   <= '0;
      sr_root_q[0]  <= '0;
      sr_rad_q[0]   <= sum_w[63:0];
      sr_ovf_q[0]   <= sum_w[64] || (sum_w[63:0] > SqLimit);
      sr_fault_q[0] <= fault4_q;
      sr_px_q[0]    <= px4_q;
    end
  end

  for (genvar g = 0; g < SqStg; g++) begin : g_sqrt
    logic [33:0] rem_d;
    logic [31:0] root_d;
    logic [63:0] rad_d;

    always_comb begin
      logic [35:0] t;
      logic [35:0] trial;
      t      = '0;
      trial  = '0;
      rem_d  = sr_rem_q[g];
      root_d = sr_root_q[g];
      rad_d  = sr_rad_q[g];
      for (int b = 0; b < SqBits; b++) begin
        t     = {rem_d, rad_d[63:62]};
        trial = {2'b00, root_d, 2'b01};
        rad_d = rad_d << 2;
        if (t >= trial) begin
          rem_d  = 34'(t - trial);
          root_d = {root_d[30:0], 1'b1};
        end else begin
          rem_d  = t[33:0];
          root_d = {root_d[30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sr_rem_q[g+1]   <= rem_d;
        sr_root_q[g+1]  <= root_d;
        sr_rad_q[g+1]   <= rad_d;
        sr_ovf_q[g+1]   <= sr_ovf_q[g];
        sr_fault_q[g+1] <= sr_fault_q[g];
        sr_px_q[g+1]    <= sr_px_q[g];
      end
    end
  end

  // --------------------------------------------------------------------------
  // output register: round the root to nearest, saturate, fault clears it
  // --------------------------------------------------------------------------
  logic [31:0] dist6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (sr_fault_q[SqStg]) begin
        dist6_q <= '0;
      end else if (sr_ovf_q[SqStg]) begin
        dist6_q <= '1;
      end else if (sr_rem_q[SqStg] > {2'b00, sr_root_q[SqStg]}) begin
        dist6_q <= sr_root_q[SqStg] + 32'd1;
      end else begin
        dist6_q <= sr_root_q[SqStg];
      end
      px6_q    <= sr_px_q[SqStg];
      fault6_q <= sr_fault_q[SqStg];
    end
  end

  assign out_o.data.proj_x      = px6_q[0];
  assign out_o.data.proj_y      = px6_q[1];
  assign out_o.data.error_dist  = dist6_q;
  assign out_o.data.depth_fault = fault6_q;

endmodule

`default_nettype wire

// File: tb/pinhole_reprojection_error_checker.sv
// ----------------------------------------------------------------------------
// pinhole_reprojection_error_checker
// watches the configuration port and both channels, predicts each projection
// and compares every output transfer with the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module pinhole_reprojection_error_checker #(
  parameter int unsigned IMAGE_WIDTH  = pre_pkg::DefImageWidth,
  parameter int unsigned IMAGE_HEIGHT = pre_pkg::DefImageHeight
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  pre_in_if           in_mon,
  pre_out_if          out_mon,
  output int          fail_count_o,
  output int          pending_o
);

  typedef logic signed [127:0] wide_t;

  logic signed [31:0] cam_x, cam_y, cam_z;
  logic signed [31:0] q_w, q_i, q_j, q_k;
  logic        [31:0] focal;
  pre_pkg::out_item_t pixel_q[$];

  assign pending_o = pixel_q.size();

  function automatic wide_t rnd30(wide_t p);
    return (p + (wide_t'(1) <<< 29)) >>> 30;
  endfunction

  function automatic wide_t sat32(wide_t v);
    if (v < -wide_t'(64'sh8000_0000)) return -wide_t'(64'sh8000_0000);
    if (v > wide_t'(64'sh7fff_ffff)) return wide_t'(64'sh7fff_ffff);
    return v;
  endfunction

  // rotation matrix entry, the diagonal ones drop 1.0 in q2.30
  function automatic wide_t rot_entry(wide_t a, wide_t b, bit diag);
    return sat32(2 * (a + b) - (diag ? wide_t'(64'sh4000_0000) : wide_t'(0)));
  endfunction

  // focal * num / den, rounded half away from zero, magnitude capped at 2^40
  function automatic wide_t focal_ratio(logic [31:0] f, wide_t num, wide_t den);
    logic        neg;
    logic [127:0] an, ad, prod, quo, rem;
    neg  = (num < 0) != (den < 0);
    an   = num < 0 ? -num : num;
    ad   = den < 0 ? -den : den;
    prod = {96'd0, f} * an;
    quo  = prod / ad;
    rem  = prod % ad;
    if (quo >= (128'd1 << 40)) quo = 128'd1 << 40;
    else if (2 * rem >= ad) quo = quo + 1;
    return neg ? -wide_t'(quo) : wide_t'(quo);
  endfunction

  function automatic pre_pkg::out_item_t project_point(pre_pkg::in_item_t it);
    pre_pkg::out_item_t res;
    wide_t        vx, vy, vz, ww, wi, wj, wk, ii, ij, ik, jj, jk, kk;
    wide_t        rx, ry, rz, px, py, dx, dy;
    logic [127:0] sq, root, trial;
    vx = wide_t'(it.obj_x) - wide_t'(cam_x);
    vy = wide_t'(it.obj_y) - wide_t'(cam_y);
    vz = wide_t'(it.obj_z) - wide_t'(cam_z);
    ww = rnd30(wide_t'(q_w) * wide_t'(q_w));
    wi = rnd30(wide_t'(q_w) * wide_t'(q_i));
    wj = rnd30(wide_t'(q_w) * wide_t'(q_j));
    wk = rnd30(wide_t'(q_w) * wide_t'(q_k));
    ii = rnd30(wide_t'(q_i) * wide_t'(q_i));
    ij = rnd30(wide_t'(q_i) * wide_t'(q_j));
    ik = rnd30(wide_t'(q_i) * wide_t'(q_k));
    jj = rnd30(wide_t'(q_j) * wide_t'(q_j));
    jk = rnd30(wide_t'(q_j) * wide_t'(q_k));
    kk = rnd30(wide_t'(q_k) * wide_t'(q_k));
    rx = rnd30(vx * rot_entry(ww, ii, 1'b1)) + rnd30(vy * rot_entry(ij, wk, 1'b0))
       + rnd30(vz * rot_entry(ik, -wj, 1'b0));
    ry = rnd30(vx * rot_entry(ij, -wk, 1'b0)) + rnd30(vy * rot_entry(ww, jj, 1'b1))
       + rnd30(vz * rot_entry(jk, wi, 1'b0));
    rz = rnd30(vx * rot_entry(ik, wj, 1'b0)) + rnd30(vy * rot_entry(jk, -wi, 1'b0))
       + rnd30(vz * rot_entry(ww, kk, 1'b1));
    res = '0;
    if (rz == 0) begin
      res.depth_fault = 1'b1;
      return res;
    end
    px = sat32(focal_ratio(focal, rx, rz) + wide_t'(IMAGE_WIDTH - 1) * 32768);
    py = sat32(focal_ratio(focal, ry, rz) + wide_t'(IMAGE_HEIGHT - 1) * 32768);
    dx = wide_t'(it.meas_x) - px;
    dy = wide_t'(it.meas_y) - py;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    sq = dx * dx + dy * dy;
    if (sq > 128'hffff_ffff_0000_0000) begin
      root = 128'hffff_ffff;
    end else begin
      root = '0;
      for (int b = 31; b >= 0; b--) begin
        trial = root | (128'd1 << b);
        if (trial * trial <= sq) root = trial;
      end
      if (sq - root * root > root) root = root + 1;
    end
    res.proj_x     = px[31:0];
    res.proj_y     = py[31:0];
    res.error_dist = root[31:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x <= pre_pkg::CamRst; cam_y <= pre_pkg::CamRst; cam_z <= pre_pkg::CamRst;
      q_w <= pre_pkg::QuatWRst; q_i <= pre_pkg::QuatVRst;
      q_j <= pre_pkg::QuatVRst; q_k <= pre_pkg::QuatVRst;
      focal <= pre_pkg::FocalRst;
      pixel_q.delete();
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (pre_pkg::cfg_idx_e'(cfg_idx_i))
          pre_pkg::CFG_CAM_X:  cam_x <= cfg_data_i;
          pre_pkg::CFG_CAM_Y:  cam_y <= cfg_data_i;
          pre_pkg::CFG_CAM_Z:  cam_z <= cfg_data_i;
          pre_pkg::CFG_QUAT_W: q_w   <= cfg_data_i;
          pre_pkg::CFG_QUAT_I: q_i   <= cfg_data_i;
          pre_pkg::CFG_QUAT_J: q_j   <= cfg_data_i;
          pre_pkg::CFG_QUAT_K: q_k   <= cfg_data_i;
          pre_pkg::CFG_FOCAL:  focal <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        pixel_q.insert(pixel_q.size(), project_point(in_mon.data));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (pixel_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_mon.data);
          fail_count_o <= fail_count_o + 1;
        end else begin
          pre_pkg::out_item_t want;
          want = pixel_q.pop_front();
          if (want !== out_mon.data) begin
            $display("%0t: mismatch proj_x exp %h got %h, proj_y exp %h got %h", $time,
                     want.proj_x, out_mon.data.proj_x, want.proj_y, out_mon.data.proj_y);
            $display("%0t:   error_dist exp %h got %h, depth_fault exp %b got %b", $time,
                     want.error_dist, out_mon.data.error_dist, want.depth_fault,
                     out_mon.data.depth_fault);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

// File: tb/pinhole_reprojection_error_unit_test.sv
// ----------------------------------------------------------------------------
// pinhole_reprojection_error_unit_test
// drives directed and random object points through several camera settings,
// with random idling on both channels, and reports the checker's verdict
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module pinhole_reprojection_error_unit_test;

  localparam int NumPhases  = 8;
  localparam int PhaseItems = 215;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [31:0] cfg_data;
  logic        quiet;
  int          out_gap_left = 0;
  int          fail_count, pending;
  logic [31:0] cam_now[3];

  pre_in_if  in_ch();
  pre_out_if out_ch();

  pinhole_reprojection_error_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  pinhole_reprojection_error_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // random value, shifted down so small and large magnitudes both show up
  function automatic logic [31:0] scaled_rand();
    logic signed [31:0] v;
    v = $urandom;
    return v >>> $urandom_range(0, 31);
  endfunction

  // output back-pressure in bursts, none when quiet
  always @(posedge clk_i) begin
    if (out_gap_left > 0) begin
      out_gap_left <= out_gap_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_gap_left <= $urandom_range(0, 10);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // one point transfer, with an occasional idle burst ahead of it
  task automatic send_point(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                            logic [31:0] mx, logic [31:0] my);
    pre_pkg::in_item_t it;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    it.obj_x = ox; it.obj_y = oy; it.obj_z = oz; it.meas_x = mx; it.meas_y = my;
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk_i); while (!(in_ch.valid && in_ch.ready));
  endtask

  // load all eight registers back to back while the pipeline is empty
  task automatic load_camera(logic [31:0] regs[8]);
    in_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (40) @(posedge clk_i);
    for (int r = 0; r < 8; r++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= pre_pkg::cfg_idx_e'(r);
      cfg_data <= regs[r];
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
    cam_now = '{regs[pre_pkg::CFG_CAM_X], regs[pre_pkg::CFG_CAM_Y],
                regs[pre_pkg::CFG_CAM_Z]};
    // let the rotation matrix settle
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] regs[8];
    logic [31:0] ox, oy, oz;
    int          pick;
    cfg_we = 1'b0; cfg_idx = pre_pkg::CFG_CAM_X; cfg_data = '0;
    in_ch.valid = 1'b0; in_ch.data = '0;
    quiet = 1'b0;
    cam_now = '{32'd0, 32'd0, 32'd0};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed points under the reset camera: identity rotation at the origin
    send_point(32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0);           // on the axis
    send_point(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);                   // zero depth
    send_point(32'h0005_0000, 32'h0003_0000, 32'h0, 32'h1, 32'h1);   // zero depth, off axis
    send_point(32'h0001_0000, 32'h0002_0000, 32'hfffc_0000,
               32'h0100_0000, 32'h0100_0000);                        // behind the camera
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h1, 32'h7fff_ffff, 32'h8000_0000);
    send_point(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0, 32'h0);
    send_point(32'h0, 32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_point(32'h0005_0000, 32'hfffd_0000, 32'h0014_0000, 32'h01ff_8000, 32'h01ff_8000);
    send_point(32'hffff_ffff, 32'h1, 32'h0000_8000, 32'h0, 32'hffff_ffff);

    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph > 0) begin
        case (ph)
          1: regs = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                      32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff};
          2: regs = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0};
          3: regs = '{scaled_rand(), scaled_rand(), scaled_rand(), 32'h0,
                      32'h4000_0000, 32'h0, 32'h0, pre_pkg::FocalRst};  // half turn about x
          4: regs = '{scaled_rand(), scaled_rand(), scaled_rand(), 32'h2d41_3ccd,
                      32'h0, 32'h2d41_3ccd, 32'h0, scaled_rand()};       // quarter turn about y
          5: regs = '{scaled_rand(), scaled_rand(), scaled_rand(), 32'h2000_0000,
                      32'h2000_0000, 32'h2000_0000, 32'h2000_0000, $urandom};
          default: regs = '{$urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom, $urandom};
        endcase
        load_camera(regs);
      end
      // final phase runs at full rate on both sides
      quiet = (ph == NumPhases - 1);
      for (int n = 0; n < PhaseItems; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          // point at the camera always has zero depth
          ox = cam_now[0]; oy = cam_now[1]; oz = cam_now[2];
        end else if (pick < 8) begin
          ox = $urandom; oy = $urandom; oz = $urandom;
        end else begin
          ox = cam_now[0] + scaled_rand();
          oy = cam_now[1] + scaled_rand();
          oz = cam_now[2] + scaled_rand();
          if (ph == 0 && pick < 14) oz = cam_now[2];
        end
        send_point(ox, oy, oz,
                   pick < 50 ? 32'h01ff_8000 + (scaled_rand() >>> 4) : $urandom,
                   pick < 50 ? 32'h01ff_8000 + (scaled_rand() >>> 4) : $urandom);
      end
    end
    in_ch.valid <= 1'b0;

    wait (pending == 0);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("pinhole_reprojection_error_unit_test OK");
    end else begin
      $display("pinhole_reprojection_error_unit_test NOT OK");
    end
    $finish;
  end

  // hang guard
  initial begin
    #20ms;
    $display("pinhole_reprojection_error_unit_test NOT OK");
    $finish;
  end
endmodule

// File: filelist.f
hdl/pre_pkg.sv
hdl/pre_in_if.sv
hdl/pre_out_if.sv
hdl/pinhole_reprojection_error_unit.sv
tb/pinhole_reprojection_error_checker.sv
tb/pinhole_reprojection_error_unit_test.sv
